// ===== src/single_wire_command_link_top_defines.svh =====
// ----------------------------------------------------------------------------
// single_wire_command_link_top_defines.svh
// Assertion macros used by the command link core.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_COMMAND_LINK_TOP_DEFINES_SVH
`define SINGLE_WIRE_COMMAND_LINK_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define SWCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define SWCL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/swcl_pkg.sv =====
// ----------------------------------------------------------------------------
// swcl_pkg
// Shared types and constants of the single-wire command link.
// ----------------------------------------------------------------------------
package swcl_pkg;

    localparam int CODE_BITS    = 3;
    localparam int FRAME_HALVES = 2 * (CODE_BITS + 2);
    localparam int PHASE_W      = 4;
    localparam int HALF_W       = 8;
    localparam int TMO_W        = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TMO  = 1'd1;

    localparam logic [HALF_W-1:0] HALF_BIT_RESET = 8'd1;
    localparam logic [TMO_W-1:0]  ACK_TMO_RESET  = 16'd1000;

    localparam logic [CODE_BITS-1:0] CODE_ACK   = 3'b001;
    localparam logic [CODE_BITS-1:0] CODE_CMD_A = 3'b010;
    localparam logic [CODE_BITS-1:0] CODE_CMD_B = 3'b100;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ACKED = 2'd1;
    localparam logic [1:0] EV_FAIL = 2'd2;
    localparam logic [1:0] EV_CMD  = 2'd3;

    typedef struct packed {
        logic [HALF_W-1:0] half_bit_ticks;
        logic [TMO_W-1:0]  ack_timeout_ticks;
    } swcl_cfg_t;

    typedef struct packed {
        logic       line_drive;
        logic       busy_res;
        logic [1:0] event_res;
        logic [2:0] event_code;
    } swcl_result_t;

endpackage

// ===== src/swcl_core.sv =====
// ----------------------------------------------------------------------------
// swcl_core
// Link state machine: one tick per step, next state and result computed
// combinationally from the registered input beat.
// ----------------------------------------------------------------------------
`include "single_wire_command_link_top_defines.svh"

module swcl_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   line_in,
    input  logic                   send_valid,
    input  logic [2:0]             send_code,
    input  swcl_pkg::swcl_cfg_t    cfg,
    output swcl_pkg::swcl_result_t res
);
    import swcl_pkg::*;

    localparam logic [2:0] M_IDLE       = 3'd0;
    localparam logic [2:0] M_SEND       = 3'd1;
    localparam logic [2:0] M_SEND_ACK   = 3'd2;
    localparam logic [2:0] M_WAIT       = 3'd3;
    localparam logic [2:0] M_RECV       = 3'd4;
    localparam logic [2:0] M_RECV_REPLY = 3'd5;

    logic [2:0]           mode_reg, mode_next;
    logic [HALF_W-1:0]    hbc_reg, hbc_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [CODE_BITS-1:0] shift_reg, shift_next;
    logic [TMO_W-1:0]     tmo_reg, tmo_next;
    logic [CODE_BITS-1:0] pend_reg, pend_next;

    logic [HALF_W-1:0]    half_ticks;
    logic [HALF_W:0]      hbc_inc;
    logic [PHASE_W-1:0]   phase_inc;
    logic [PHASE_W-2:0]   bit_no;
    logic                 fresh;
    logic                 abort;
    logic                 done;
    logic                 drive;
    logic [1:0]           ev;
    logic [2:0]           evc;

    assign half_ticks = (cfg.half_bit_ticks == '0) ? HALF_W'(1) : cfg.half_bit_ticks;

    always_comb
    begin
        mode_next  = mode_reg;
        hbc_next   = hbc_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        tmo_next   = tmo_reg;
        pend_next  = pend_reg;
        fresh      = 1'b0;
        abort      = 1'b0;
        done       = 1'b0;
        drive      = 1'b1;
        ev         = EV_NONE;
        evc        = 3'd0;
        bit_no     = '0;
        hbc_inc    = '0;
        phase_inc  = '0;

        if (mode_reg == M_IDLE)
        begin
            if (send_valid)
            begin
                mode_next  = M_SEND;
                hbc_next   = '0;
                phase_next = '0;
                shift_next = send_code[CODE_BITS-1:0];
            end
            else if (!line_in)
            begin
                mode_next  = M_RECV;
                hbc_next   = '0;
                phase_next = '0;
                shift_next = '0;
                fresh      = 1'b1;
            end
        end

        hbc_inc   = {1'b0, hbc_next} + (HALF_W+1)'(1);
        phase_inc = phase_next + PHASE_W'(1);

        if (mode_next == M_SEND || mode_next == M_SEND_ACK)
        begin
            bit_no = phase_next[PHASE_W-1:1];
            if (bit_no == '0)
                drive = 1'b0;
            else if (bit_no <= (PHASE_W-1)'(CODE_BITS))
                drive = shift_next[2'(bit_no - (PHASE_W-1)'(1))];
            else
                drive = 1'b1;
            if (hbc_inc >= {1'b0, half_ticks})
            begin
                hbc_next   = '0;
                phase_next = phase_inc;
                if (phase_inc >= PHASE_W'(FRAME_HALVES))
                begin
                    if (mode_next == M_SEND)
                    begin
                        if (cfg.ack_timeout_ticks == '0)
                        begin
                            ev        = EV_FAIL;
                            mode_next = M_IDLE;
                        end
                        else
                        begin
                            tmo_next  = cfg.ack_timeout_ticks;
                            mode_next = M_WAIT;
                        end
                    end
                    else
                    begin
                        ev        = EV_CMD;
                        evc       = 3'(pend_reg);
                        mode_next = M_IDLE;
                    end
                end
            end
            else
            begin
                hbc_next = hbc_inc[HALF_W-1:0];
            end
        end
        else if (mode_next == M_WAIT)
        begin
            if (!line_in)
            begin
                mode_next  = M_RECV_REPLY;
                hbc_next   = '0;
                phase_next = '0;
                shift_next = '0;
            end
            else
            begin
                tmo_next = tmo_reg - TMO_W'(1);
                if (tmo_next == '0)
                begin
                    ev        = EV_FAIL;
                    mode_next = M_IDLE;
                end
            end
        end
        else if ((mode_next == M_RECV || mode_next == M_RECV_REPLY) && !fresh)
        begin
            if (hbc_inc >= {1'b0, half_ticks})
            begin
                hbc_next   = '0;
                phase_next = phase_inc;
                if (phase_inc == PHASE_W'(1))
                    abort = line_in;
                else if (phase_inc == PHASE_W'(2 * CODE_BITS + 3))
                    abort = !line_in;
                else if (phase_inc >= PHASE_W'(FRAME_HALVES))
                    done = 1'b1;
                else
                begin
                    for (int i = 0; i < CODE_BITS; i++)
                    begin
                        if (phase_inc == PHASE_W'(2 * i + 3) && line_in)
                            shift_next[i] = 1'b1;
                    end
                end

                if (abort)
                begin
                    if (mode_next == M_RECV_REPLY)
                        ev = EV_FAIL;
                    mode_next = M_IDLE;
                end
                else if (done)
                begin
                    if (mode_next == M_RECV_REPLY)
                    begin
                        ev        = (shift_next == CODE_ACK) ? EV_ACKED : EV_FAIL;
                        mode_next = M_IDLE;
                    end
                    else if (shift_next == CODE_CMD_A || shift_next == CODE_CMD_B)
                    begin
                        pend_next  = shift_next;
                        mode_next  = M_SEND_ACK;
                        hbc_next   = '0;
                        phase_next = '0;
                        shift_next = CODE_ACK;
                    end
                    else
                    begin
                        mode_next = M_IDLE;
                    end
                end
            end
            else
            begin
                hbc_next = hbc_inc[HALF_W-1:0];
            end
        end
    end

    assign res.line_drive = drive;
    assign res.busy_res   = (mode_next != M_IDLE);
    assign res.event_res  = ev;
    assign res.event_code = evc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            hbc_reg   <= '0;
            phase_reg <= '0;
            shift_reg <= '0;
            tmo_reg   <= '0;
            pend_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            hbc_reg   <= hbc_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            tmo_reg   <= tmo_next;
            pend_reg  <= pend_next;
        end
    end

    `SWCL_ASSERT(a_event_ends_busy,
        (res.event_res != EV_NONE) |-> !res.busy_res,
        "event reported while link stays busy")
    `SWCL_ASSERT(a_code_only_on_cmd,
        (res.event_code != 3'd0) |-> (res.event_res == EV_CMD),
        "event code without received command")
    `SWCL_ASSERT(a_hold_without_step,
        !step |=> ($stable(mode_reg) && $stable(phase_reg) && $stable(tmo_reg)),
        "link state moved without a tick")
    `SWCL_ASSERT(a_phase_in_frame,
        phase_reg <= PHASE_W'(FRAME_HALVES),
        "frame phase beyond frame length")
    `SWCL_ASSERT_ALWAYS(a_idle_after_reset,
        !rst_n |=> (mode_reg == M_IDLE),
        "link not idle after reset")

endmodule

// ===== src/single_wire_command_link_top.sv =====
// ----------------------------------------------------------------------------
// single_wire_command_link_top
// Half-duplex open-drain one-wire command link, one line tick per beat.
//
// Input channel (in_valid/in_ready) carries one tick: the sampled line level
// and an optional send request. Output channel (out_valid/out_ready) returns
// exactly one result beat per input beat: line drive, busy flag, event and
// received code, in order.
// Path: an accepted input beat goes to the input register, then its result
// to the result register, from which the receiver takes it.
// Throughput: one beat per cycle while the receiver does not stall; the tick
// logic is a single pass between those two registers.
// When the receiver stalls the result register holds, an empty input register
// still takes one more beat, then in_ready drops until the result drains.
// Reset clears both valid flags, idles the link and sets the half-bit
// length to 1 tick and reply timeout to 1000 ticks. The user must write
// configuration (cfg_we, cfg_index, cfg_data) with the link idle; unchecked.
// ----------------------------------------------------------------------------
module single_wire_command_link_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                line_in,
    input  logic                                send_valid,
    input  logic [2:0]                          send_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                line_drive,
    output logic                                busy_res,
    output logic [1:0]                          event_res,
    output logic [2:0]                          event_code,
    input  logic                                cfg_we,
    input  logic [swcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swcl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swcl_pkg::*;

    logic         in_valid_reg;
    logic         line_reg;
    logic         send_valid_reg;
    logic [2:0]   send_code_reg;
    logic         out_valid_reg;
    swcl_result_t res_reg;
    swcl_result_t res_next;
    swcl_cfg_t    cfg_reg;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks    <= HALF_BIT_RESET;
            cfg_reg.ack_timeout_ticks <= ACK_TMO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_BIT: cfg_reg.half_bit_ticks    <= cfg_data[HALF_W-1:0];
                CFG_ACK_TMO:  cfg_reg.ack_timeout_ticks <= cfg_data[TMO_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            line_reg       <= line_in;
            send_valid_reg <= send_valid;
            send_code_reg  <= send_code;
        end
        if (advance)
            res_reg <= res_next;
    end

    swcl_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .line_in    (line_reg),
        .send_valid (send_valid_reg),
        .send_code  (send_code_reg),
        .cfg        (cfg_reg),
        .res        (res_next)
    );

    assign out_valid  = out_valid_reg;
    assign line_drive = res_reg.line_drive;
    assign busy_res   = res_reg.busy_res;
    assign event_res  = res_reg.event_res;
    assign event_code = res_reg.event_code;

endmodule
